[rtl/imu_tilt_complementary_filter_defines.svh]
// -----------------------------------------------------------------------------
// IMU tilt filter assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is high.
// -----------------------------------------------------------------------------
`ifndef IMU_TILT_COMPLEMENTARY_FILTER_DEFINES_SVH
`define IMU_TILT_COMPLEMENTARY_FILTER_DEFINES_SVH

// same-cycle implication
`define ITCF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITCF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/itcf_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// itcf_pkg
// Widths, fixed-point constants, CORDIC arctangent table and the structs
// shared by the tilt filter modules.
// -----------------------------------------------------------------------------
package itcf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int WEIGHT_W    = 16;
  localparam int STEP_W      = 16;
  localparam int FUSED_W     = 24;
  localparam int TILT_W      = 17;
  localparam int EST_W       = 40;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam int CX_W        = 34;  // CORDIC x / y
  localparam int CZ_W        = 32;  // CORDIC angle, Q20 degrees
  localparam int ZQ_W        = 29;  // clamped tilt, Q20 degrees
  localparam int ATAN_LEN    = 24;
  localparam int PRE_SHIFT   = 14;
  localparam int CORDIC_FRAC = 20;
  localparam int BLEND_FRAC  = 16;
  localparam int STEP_FRAC   = 24;

  localparam logic signed [CZ_W-1:0] DEG180_Q20 = 32'sd188743680;

  localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RST = 16'd655;
  localparam logic [STEP_W-1:0]   GYRO_STEP_RST    = 16'd2557;

  localparam logic [CFG_INDEX_W-1:0] REG_BLEND_WEIGHT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GYRO_STEP    = 8'd1;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic                       start;
    logic                       zero;
    logic signed [SAMPLE_W-1:0] gyro;
    logic signed [CZ_W-1:0]     z;
  } blend_req_t;

  typedef struct packed {
    logic                      valid;
    logic signed [FUSED_W-1:0] fused;
    logic signed [TILT_W-1:0]  tilt;
  } blend_res_t;

  // atan(2^-i) in degrees, Q20
  function automatic logic signed [CZ_W-1:0] atan_q20(input int unsigned idx);
    logic signed [CZ_W-1:0] v;
    case (idx)
      0:       v = 32'sd47185920;
      1:       v = 32'sd27855475;
      2:       v = 32'sd14718068;
      3:       v = 32'sd7471121;
      4:       v = 32'sd3750058;
      5:       v = 32'sd1876857;
      6:       v = 32'sd938658;
      7:       v = 32'sd469357;
      8:       v = 32'sd234682;
      9:       v = 32'sd117342;
      10:      v = 32'sd58671;
      11:      v = 32'sd29335;
      12:      v = 32'sd14668;
      13:      v = 32'sd7334;
      14:      v = 32'sd3667;
      15:      v = 32'sd1833;
      16:      v = 32'sd917;
      17:      v = 32'sd458;
      18:      v = 32'sd229;
      19:      v = 32'sd115;
      20:      v = 32'sd57;
      21:      v = 32'sd29;
      22:      v = 32'sd14;
      23:      v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/itcf_sample_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// itcf_sample_if
// IMU sample channel: accelerometer X and Z, gyro Y.
// -----------------------------------------------------------------------------
interface itcf_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [itcf_pkg::SAMPLE_W-1:0] accel_x;
  logic signed [itcf_pkg::SAMPLE_W-1:0] accel_z;
  logic signed [itcf_pkg::SAMPLE_W-1:0] gyro_y;

  modport source (output valid, output accel_x, output accel_z, output gyro_y,
                  input ready);
  modport sink (input valid, input accel_x, input accel_z, input gyro_y,
                output ready);
endinterface

[rtl/itcf_result_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// itcf_result_if
// Result channel: fused angle estimate and accelerometer-only tilt.
// -----------------------------------------------------------------------------
interface itcf_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [itcf_pkg::FUSED_W-1:0] fused_angle;
  logic signed [itcf_pkg::TILT_W-1:0]  accel_tilt;

  modport source (output valid, output fused_angle, output accel_tilt, input ready);
  modport sink (input valid, input fused_angle, input accel_tilt, output ready);
endinterface

[rtl/itcf_cfg_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// itcf_cfg_if
// Register write channel: register index and write data.
// -----------------------------------------------------------------------------
interface itcf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [itcf_pkg::CFG_INDEX_W-1:0]    index;
  logic [itcf_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/itcf_cordic_cell.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// itcf_cordic_cell
// One vectoring CORDIC micro-rotation, registered. Cells are chained so the
// vector moves one cell per cycle.
// -----------------------------------------------------------------------------
module itcf_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  itcf_pkg::cordic_t in_d,
  output logic              out_vld,
  output itcf_pkg::cordic_t out_d
);

  localparam int CX_W = itcf_pkg::CX_W;
  localparam int CZ_W = itcf_pkg::CZ_W;
  localparam logic signed [CZ_W-1:0] ATAN = itcf_pkg::atan_q20(STAGE);

  logic signed [CX_W-1:0] xi, yi, dx, dy;
  logic signed [CZ_W-1:0] zi;
  itcf_pkg::cordic_t      d_next;

  assign xi = in_d.x;
  assign yi = in_d.y;
  assign zi = in_d.z;
  assign dx = yi >>> STAGE;
  assign dy = xi >>> STAGE;

  always_comb begin
    if (yi > 0) begin
      d_next.x = xi + dx;
      d_next.y = yi - dy;
      d_next.z = zi + ATAN;
    end else begin
      d_next.x = xi - dx;
      d_next.y = yi + dy;
      d_next.z = zi - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_d <= d_next;
  end

endmodule

[rtl/itcf_blend.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// itcf_blend
// Tilt clamp, gyro increment and complementary blend of the kept estimate.
// Sequenced as registered steps (S_CLAMP to S_SAT), at most one multiplier per step.
// -----------------------------------------------------------------------------
`include "imu_tilt_complementary_filter_defines.svh"

module itcf_blend #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  itcf_pkg::blend_req_t           req,
  input  logic [itcf_pkg::WEIGHT_W-1:0]  blend_weight,
  input  logic [itcf_pkg::STEP_W-1:0]    gyro_step,
  input  logic                           res_take,
  output itcf_pkg::blend_res_t           res
);

  localparam int SAMPLE_W = itcf_pkg::SAMPLE_W;
  localparam int WEIGHT_W = itcf_pkg::WEIGHT_W;
  localparam int STEP_W   = itcf_pkg::STEP_W;
  localparam int EST_W    = itcf_pkg::EST_W;
  localparam int ZQ_W     = itcf_pkg::ZQ_W;
  localparam int CZ_W     = itcf_pkg::CZ_W;
  localparam int FUSED_W  = itcf_pkg::FUSED_W;
  localparam int TILT_W   = itcf_pkg::TILT_W;

  localparam int EST_FRAC = ANGLE_FRAC_BITS + itcf_pkg::BLEND_FRAC;
  localparam int INC_LSH  = (EST_FRAC > itcf_pkg::STEP_FRAC) ?
                            EST_FRAC - itcf_pkg::STEP_FRAC : 0;
  localparam int INC_RSH  = (EST_FRAC < itcf_pkg::STEP_FRAC) ?
                            itcf_pkg::STEP_FRAC - EST_FRAC : 0;
  localparam int INC_RND  = (INC_RSH > 0) ? (1 << (INC_RSH - 1)) : 0;
  localparam int RAW_W    = SAMPLE_W + STEP_W + 2;
  localparam int INC_W    = RAW_W + INC_LSH;
  localparam int A_W      = ((INC_W > EST_W) ? INC_W : EST_W) + 1;
  localparam int SPLIT_W  = 24;
  localparam int A_HI_W   = A_W - SPLIT_W;
  localparam int M_W      = WEIGHT_W + 1;
  localparam int PT_W     = M_W + ZQ_W;
  localparam int PLO_W    = M_W + SPLIT_W;
  localparam int PHI_W    = M_W + 1 + A_HI_W;
  localparam int TSH      = EST_FRAC - itcf_pkg::CORDIC_FRAC;
  localparam int SUM_W    = A_W + M_W + 2;
  localparam int ESTF_W   = SUM_W - itcf_pkg::BLEND_FRAC;
  localparam int TQ_W     = ZQ_W + 1;
  localparam int TILT_RSH = itcf_pkg::CORDIC_FRAC - ANGLE_FRAC_BITS;

  localparam logic [M_W-1:0] M_FULL = M_W'(1) << WEIGHT_W;
  localparam logic signed [RAW_W:0] INC_RND_S = (RAW_W + 1)'(INC_RND);
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (itcf_pkg::BLEND_FRAC - 1);
  localparam logic signed [TQ_W-1:0] TILT_RND = TQ_W'(1) <<< (TILT_RSH - 1);
  localparam logic signed [TQ_W-1:0] TILT_HI = (TQ_W'(1) <<< (TILT_W - 1)) - TQ_W'(1);
  localparam logic signed [TQ_W-1:0] TILT_LO = -(TQ_W'(1) <<< (TILT_W - 1));
  localparam logic signed [ESTF_W-1:0] EST_HI =
    {{(ESTF_W - EST_W + 1){1'b0}}, {(EST_W - 1){1'b1}}};
  localparam logic signed [ESTF_W-1:0] EST_LO =
    {{(ESTF_W - EST_W + 1){1'b1}}, {(EST_W - 1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_CLAMP, S_INC, S_ADD, S_LO, S_HI, S_SUM, S_SAT, S_DONE
  } state_t;

  state_t state;

  logic signed [CZ_W-1:0]     zr;
  logic signed [SAMPLE_W-1:0] gy_r;
  logic                       zero_r;
  logic signed [ZQ_W-1:0]     zq, zq_next;
  logic signed [RAW_W-1:0]    rinc, rinc_next;
  logic [M_W-1:0]             m, m_next;
  logic signed [INC_W-1:0]    inc, inc_next;
  logic signed [PT_W-1:0]     pt, pt_next;
  logic signed [A_W-1:0]      a, a_next;
  logic [PLO_W-1:0]           plo, plo_next;
  logic signed [PHI_W-1:0]    phi, phi_next;
  logic signed [SUM_W-1:0]    acc, acc_next;
  logic signed [SUM_W-1:0]    sum, sum_next;
  logic signed [EST_W-1:0]    est, est_next;
  logic signed [FUSED_W-1:0]  fused_r;
  logic signed [TILT_W-1:0]   tilt_r, tilt_next;
  logic signed [SAMPLE_W:0]   negy;
  logic signed [RAW_W:0]      rinc_rnd;
  logic signed [TQ_W-1:0]     tq;
  logic signed [ESTF_W-1:0]   estf;

  always_comb begin
    if (zero_r) begin
      zq_next = '0;
    end else if (zr > itcf_pkg::DEG180_Q20) begin
      zq_next = ZQ_W'(itcf_pkg::DEG180_Q20);
    end else if (zr < -itcf_pkg::DEG180_Q20) begin
      zq_next = ZQ_W'(-itcf_pkg::DEG180_Q20);
    end else begin
      zq_next = ZQ_W'(zr);
    end
  end

  assign negy      = -((SAMPLE_W + 1)'(gy_r));
  assign rinc_next = negy * $signed({1'b0, gyro_step});
  assign m_next    = M_FULL - M_W'(blend_weight);

  assign rinc_rnd  = (RAW_W + 1)'(rinc) + INC_RND_S;

  always_comb begin
    if (INC_RSH > 0) begin
      inc_next = INC_W'(rinc_rnd >>> INC_RSH);
    end else begin
      inc_next = INC_W'(rinc) <<< INC_LSH;
    end
  end

  assign pt_next = $signed({1'b0, blend_weight}) * zq;

  assign tq = (TQ_W'(zq) + TILT_RND) >>> TILT_RSH;

  always_comb begin
    if (tq > TILT_HI) begin
      tilt_next = TILT_W'(TILT_HI);
    end else if (tq < TILT_LO) begin
      tilt_next = TILT_W'(TILT_LO);
    end else begin
      tilt_next = TILT_W'(tq);
    end
  end

  assign a_next   = A_W'(est) + A_W'(inc);
  assign plo_next = m * a[SPLIT_W-1:0];
  assign phi_next = $signed({1'b0, m}) * $signed(a[A_W-1:SPLIT_W]);
  assign acc_next = $signed(SUM_W'(plo)) + (SUM_W'(pt) <<< TSH) + RND_HALF;
  assign sum_next = acc + (SUM_W'(phi) <<< SPLIT_W);
  assign estf     = ESTF_W'(sum >>> itcf_pkg::BLEND_FRAC);

  always_comb begin
    if (estf > EST_HI) begin
      est_next = EST_W'(EST_HI);
    end else if (estf < EST_LO) begin
      est_next = EST_W'(EST_LO);
    end else begin
      est_next = EST_W'(estf);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      est   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            zr     <= req.z;
            gy_r   <= req.gyro;
            zero_r <= req.zero;
            state  <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          zq    <= zq_next;
          rinc  <= rinc_next;
          m     <= m_next;
          state <= S_INC;
        end
        S_INC: begin
          inc    <= inc_next;
          pt     <= pt_next;
          tilt_r <= tilt_next;
          state  <= S_ADD;
        end
        S_ADD: begin
          a     <= a_next;
          state <= S_LO;
        end
        S_LO: begin
          plo   <= plo_next;
          state <= S_HI;
        end
        S_HI: begin
          phi   <= phi_next;
          acc   <= acc_next;
          state <= S_SUM;
        end
        S_SUM: begin
          sum   <= sum_next;
          state <= S_SAT;
        end
        S_SAT: begin
          est     <= est_next;
          fused_r <= est_next[EST_W-1 -: FUSED_W];
          state   <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid = (state == S_DONE);
  assign res.fused = fused_r;
  assign res.tilt  = tilt_r;

  `ITCF_ASSERT_IMPL(a_start_idle, clk, rst, req.start, state == S_IDLE, "sample reached blend while busy")
  `ITCF_ASSERT_IMPL(a_est_write, clk, rst, !$past(rst) && !$stable(est), $past(state) == S_SAT, "estimate changed outside update step")
  `ITCF_ASSERT_NEXT(a_done_hold, clk, rst, state == S_DONE && !res_take, state == S_DONE, "result dropped before taken")

endmodule

[rtl/imu_tilt_complementary_filter.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// imu_tilt_complementary_filter
// Accelerometer tilt by CORDIC atan2, fused with the integrated gyro rate.
// -----------------------------------------------------------------------------
// Usage:
//   sample : valid/ready sink, one beat per IMU sample (accel X, accel Z, gyro Y).
//   result : valid/ready source, one beat per sample: fused_angle and accel_tilt,
//            both in 2^-ANGLE_FRAC_BITS degree.
//   cfg    : register writes, index 0 blend_weight (Q0.16), index 1 gyro_step
//            (deg per count per sample, Q24). Always ready; write only while idle.
// Timing:
//   One sample at a time. The sample passes a pre-rotation register and a chain
//   of CORDIC_STEPS cells (one micro-rotation per cycle), then a seven-step
//   blend sequencer with at most one multiplier per step. No new sample is
//   taken until the blend result has been loaded into the output register.
// Stall:
//   The output register holds the result until taken; the next sample is still
//   accepted and processed, and waits in the blend unit if the register is full.
// Reset:
//   Clears the estimate to zero and restores the default register values.
// -----------------------------------------------------------------------------
`include "imu_tilt_complementary_filter_defines.svh"

module imu_tilt_complementary_filter #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  itcf_sample_if.sink   sample,
  itcf_result_if.source result,
  itcf_cfg_if.sink      cfg
);

  localparam int CX_W     = itcf_pkg::CX_W;
  localparam int SAMPLE_W = itcf_pkg::SAMPLE_W;
  localparam int WEIGHT_W = itcf_pkg::WEIGHT_W;
  localparam int STEP_W   = itcf_pkg::STEP_W;

  logic [WEIGHT_W-1:0] blend_weight;
  logic [STEP_W-1:0]   gyro_step;

  logic                       busy;
  logic                       pre_vld;
  itcf_pkg::cordic_t          pre_d, pre_next;
  logic signed [SAMPLE_W-1:0] gy_r;
  logic                       zero_r;
  logic                       accept;

  logic [CORDIC_STEPS:0] link_vld;
  itcf_pkg::cordic_t     link_d [0:CORDIC_STEPS];

  itcf_pkg::blend_req_t blend_req;
  itcf_pkg::blend_res_t blend_res;
  logic                 res_take;
  logic                 res_load;

  logic                                out_valid;
  logic signed [itcf_pkg::FUSED_W-1:0] out_fused;
  logic signed [itcf_pkg::TILT_W-1:0]  out_tilt;

  logic signed [CX_W-1:0] ax_ext, az_ext;

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= itcf_pkg::BLEND_WEIGHT_RST;
      gyro_step    <= itcf_pkg::GYRO_STEP_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        itcf_pkg::REG_BLEND_WEIGHT: blend_weight <= cfg.data[WEIGHT_W-1:0];
        itcf_pkg::REG_GYRO_STEP:    gyro_step    <= cfg.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // input and pre-rotation
  assign sample.ready = !busy;
  assign accept       = sample.valid && sample.ready;

  assign ax_ext = CX_W'(sample.accel_x) <<< itcf_pkg::PRE_SHIFT;
  assign az_ext = CX_W'(sample.accel_z) <<< itcf_pkg::PRE_SHIFT;

  always_comb begin
    if (sample.accel_z < 0) begin
      pre_next.x = -az_ext;
      pre_next.y = -ax_ext;
      pre_next.z = (sample.accel_x >= 0) ? itcf_pkg::DEG180_Q20 : -itcf_pkg::DEG180_Q20;
    end else begin
      pre_next.x = az_ext;
      pre_next.y = ax_ext;
      pre_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      pre_vld <= 1'b0;
    end else begin
      pre_vld <= accept;
      if (accept) begin
        busy <= 1'b1;
      end else if (res_load) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pre_d  <= pre_next;
      gy_r   <= sample.gyro_y;
      zero_r <= (sample.accel_x == '0) && (sample.accel_z == '0);
    end
  end

  // CORDIC cell chain
  assign link_vld[0] = pre_vld;
  assign link_d[0]   = pre_d;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    itcf_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (link_vld[k]),
      .in_d    (link_d[k]),
      .out_vld (link_vld[k+1]),
      .out_d   (link_d[k+1])
    );
  end

  // blend
  assign blend_req.start = link_vld[CORDIC_STEPS];
  assign blend_req.zero  = zero_r;
  assign blend_req.gyro  = gy_r;
  assign blend_req.z     = link_d[CORDIC_STEPS].z;

  assign res_take = !out_valid || result.ready;
  assign res_load = blend_res.valid && res_take;

  itcf_blend #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_blend (
    .clk          (clk),
    .rst          (rst),
    .req          (blend_req),
    .blend_weight (blend_weight),
    .gyro_step    (gyro_step),
    .res_take     (res_take),
    .res          (blend_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_fused <= blend_res.fused;
      out_tilt  <= blend_res.tilt;
    end
  end

  assign result.valid       = out_valid;
  assign result.fused_angle = out_fused;
  assign result.accel_tilt  = out_tilt;

  `ITCF_ASSERT_IMPL(a_one_in_chain, clk, rst, 1'b1, $onehot0(link_vld), "more than one sample in CORDIC chain")
  `ITCF_ASSERT_IMPL(a_chain_busy, clk, rst, link_vld != '0, busy, "CORDIC chain active while idle")
  `ITCF_ASSERT_IMPL(a_busy_fall, clk, rst, $fell(busy), $past(res_load), "busy cleared without a result beat")

endmodule
